// ===== rtl/mcg_pkg.sv =====
// Shared types, constants and helper functions of the MIDI chord generator.
package mcg_pkg;

  localparam int NOTE_COUNT    = 128;
  localparam int KEY_W         = 7;
  localparam int STRIKE_W      = 7;
  localparam int CHAN_W        = 4;
  localparam int POSITION_BITS = 16;
  localparam int TYPE_W        = 3;
  localparam int CHORD_NOTES   = 4;
  localparam int SLOTS         = 2 * CHORD_NOTES;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int IVL_W         = 4;
  localparam int GROUP_W       = 8;
  localparam int GROUPS        = NOTE_COUNT / GROUP_W;
  localparam int GROUP_IDX_W   = $clog2(GROUPS);
  localparam int GROUP_BIT_W   = $clog2(GROUP_W);
  // Packed stream fields, rounded up to whole bytes on the bus.
  localparam int FIELDS_W      = KEY_W + STRIKE_W + CHAN_W + POSITION_BITS;
  localparam int DATA_W        = ((FIELDS_W + 7) / 8) * 8;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  localparam logic [TYPE_W-1:0] CHORD_MAJOR     = 3'd0;
  localparam logic [TYPE_W-1:0] CHORD_MINOR     = 3'd1;
  localparam logic [TYPE_W-1:0] CHORD_SEVENTH   = 3'd2;
  localparam logic [TYPE_W-1:0] CHORD_MAJ_SEVEN = 3'd3;
  localparam logic [TYPE_W-1:0] CHORD_SUS4      = 3'd4;

  typedef logic [KEY_W-1:0]         key_t;
  typedef logic [STRIKE_W-1:0]      strike_t;
  typedef logic [CHAN_W-1:0]        chan_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [TYPE_W-1:0]        ctype_t;
  typedef logic [CHORD_NOTES-1:0][IVL_W-1:0] ivl_set_t;

  // One note event as it arrives on the input channel.
  typedef struct packed {
    logic    opcode;
    key_t    key;
    strike_t strike;
    chan_t   chan;
    pos_t    position;
  } evt_t;

  // All results caused by one event: slots 0..3 are note offs of the old
  // chord, slots 4..7 note ons of the new one; mask marks slots to send.
  typedef struct packed {
    logic [SLOTS-1:0] mask;
    key_t [SLOTS-1:0] keys;
    strike_t          strike;
    chan_t            chan;
    pos_t             position;
  } batch_t;

  // Interval set of a chord type; undefined codes fall back to major.
  function automatic ivl_set_t chord_intervals(input ctype_t t);
    ivl_set_t iv;
    case (t)
      CHORD_MAJOR:     iv = {4'd12, 4'd7, 4'd4, 4'd0};
      CHORD_MINOR:     iv = {4'd12, 4'd7, 4'd3, 4'd0};
      CHORD_SEVENTH:   iv = {4'd10, 4'd7, 4'd4, 4'd0};
      CHORD_MAJ_SEVEN: iv = {4'd11, 4'd7, 4'd4, 4'd0};
      CHORD_SUS4:      iv = {4'd12, 4'd7, 4'd5, 4'd0};
      default:         iv = {4'd12, 4'd7, 4'd4, 4'd0};
    endcase
    return iv;
  endfunction

  // Index of the lowest set bit of a slot mask (0 when the mask is empty).
  function automatic logic [SLOT_W-1:0] lowest_slot(input logic [SLOTS-1:0] m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/mcg_note_tracker.sv =====
// Held-note map, chord state and chord-type register; builds the result batch of one event.
module mcg_note_tracker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  mcg_pkg::ctype_t         cfg_wr_data,
  input  mcg_pkg::evt_t           evt,
  input  logic                    commit,
  output mcg_pkg::batch_t         batch,
  output logic                    batch_nonempty
);
  import mcg_pkg::*;

  logic [NOTE_COUNT-1:0] held_map_r, held_map_nxt;
  logic                  chord_on_r, chord_on_nxt;
  key_t                  prev_root_r, prev_root_nxt;
  ctype_t                chord_type_r;

  logic [GROUPS-1:0]      grp_any;
  logic [GROUP_IDX_W-1:0] grp_idx;
  logic [GROUP_W-1:0]     grp_bits;
  logic [GROUP_BIT_W-1:0] bit_idx;
  key_t                   lowest;
  logic                   map_empty;
  logic [NOTE_COUNT-1:0]  key_onehot;
  logic                   empty_after;
  logic                   is_press;
  key_t                   root;
  logic                   new_chord;
  logic                   send_off;
  ivl_set_t               ivl;
  logic [KEY_W:0]         sum_off [CHORD_NOTES];
  logic [KEY_W:0]         sum_on  [CHORD_NOTES];

  // Lowest held key: first non-empty group of eight, then the bit inside it.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |held_map_r[g*GROUP_W +: GROUP_W];
    end
    grp_idx = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) grp_idx = GROUP_IDX_W'(g);
    end
    grp_bits = held_map_r[grp_idx*GROUP_W +: GROUP_W];
    bit_idx  = '0;
    for (int b = GROUP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) bit_idx = GROUP_BIT_W'(b);
    end
    lowest    = {grp_idx, bit_idx};
    map_empty = ~|grp_any;
  end

  always_comb begin
    key_onehot  = '0;
    key_onehot[evt.key] = 1'b1;
    empty_after = ~|(held_map_r & ~key_onehot);
    is_press    = (evt.opcode == OP_NOTE_ON) && (evt.strike != '0);
    if (map_empty || (evt.key < lowest)) begin
      root = evt.key;
    end else begin
      root = lowest;
    end
    new_chord = is_press && ((root != prev_root_r) || !chord_on_r);
    send_off  = chord_on_r && (new_chord || (!is_press && empty_after));
    ivl       = chord_intervals(chord_type_r);
  end

  always_comb begin
    for (int i = 0; i < CHORD_NOTES; i++) begin
      sum_off[i] = {1'b0, prev_root_r} + {{(KEY_W+1-IVL_W){1'b0}}, ivl[i]};
      sum_on[i]  = {1'b0, root} + {{(KEY_W+1-IVL_W){1'b0}}, ivl[i]};
      batch.keys[i]               = sum_off[i][KEY_W-1:0];
      batch.keys[i+CHORD_NOTES]   = sum_on[i][KEY_W-1:0];
      batch.mask[i]               = send_off && !sum_off[i][KEY_W];
      batch.mask[i+CHORD_NOTES]   = new_chord && !sum_on[i][KEY_W];
    end
    batch.strike   = evt.strike;
    batch.chan     = evt.chan;
    batch.position = evt.position;
    batch_nonempty = send_off || new_chord;
  end

  always_comb begin
    held_map_nxt  = held_map_r;
    chord_on_nxt  = chord_on_r;
    prev_root_nxt = prev_root_r;
    if (commit) begin
      if (is_press) begin
        held_map_nxt = held_map_r | key_onehot;
        if (new_chord) begin
          chord_on_nxt  = 1'b1;
          prev_root_nxt = root;
        end
      end else begin
        held_map_nxt = held_map_r & ~key_onehot;
        if (empty_after) chord_on_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_map_r   <= '0;
      chord_on_r   <= 1'b0;
      prev_root_r  <= '0;
      chord_type_r <= CHORD_MAJOR;
    end else begin
      held_map_r  <= held_map_nxt;
      chord_on_r  <= chord_on_nxt;
      prev_root_r <= prev_root_nxt;
      if (cfg_wr_en) chord_type_r <= cfg_wr_data;
    end
  end

endmodule

// ===== rtl/mcg_result_seq.sv =====
// Result batch register that sends the notes of one event one per cycle while out_ready is high.
module mcg_result_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  mcg_pkg::batch_t         batch_in,
  output logic                    can_load,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_is_on,
  output mcg_pkg::key_t           out_key,
  output mcg_pkg::strike_t        out_strike,
  output mcg_pkg::chan_t          out_chan,
  output mcg_pkg::pos_t           out_position,
  output logic                    out_last
);
  import mcg_pkg::*;

  logic [SLOTS-1:0] mask_r, mask_nxt;
  batch_t           data_r;
  logic [SLOT_W-1:0] idx;
  logic [SLOTS-1:0] idx_onehot;
  logic             pop;

  always_comb begin
    idx        = lowest_slot(mask_r);
    idx_onehot = '0;
    idx_onehot[idx] = 1'b1;
    out_valid    = |mask_r;
    out_last     = ~|(mask_r & ~idx_onehot);
    out_is_on    = idx[SLOT_W-1];
    out_key      = data_r.keys[idx];
    out_strike   = idx[SLOT_W-1] ? data_r.strike : '0;
    out_chan     = data_r.chan;
    out_position = data_r.position;
    pop          = out_valid && out_ready;
    can_load     = !out_valid || (pop && out_last);
    mask_nxt     = pop ? (mask_r & ~idx_onehot) : mask_r;
    if (load) mask_nxt = batch_in.mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= batch_in;
  end

endmodule

// ===== rtl/midi_chord_generator.sv =====
// Top level of the MIDI chord generator: input register, note tracker and result sequencer.
//
// Usage: each input transaction is one note event. A note on (nonzero
// strike) adds its key to the held set; a note off, or a note on with zero
// strike, removes it. The chord root is the lowest held key. When the root
// changes, or no chord sounds yet, the block sends note offs for the old
// four-note chord and then note ons for the new one; releasing the last held
// key sends the note offs. Chord notes above 127 are skipped. One event
// causes zero to eight result transactions, tlast marking the final one.
// The user writes the chord type through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
// An event is registered at the input and processed by the note tracker; its
// batch is then registered in the result sequencer, which sends the results.
// Throughput: events that cause no result are taken every cycle; an event
// with N results holds the result register until all N are taken, and
// the next event's batch is loaded in the cycle the last one is taken.
// Reset clears the held set, the sounding flag, the root and selects major.
// When the receiver stalls, the current result holds steady on out_tdata;
// one further event waits in the input register, then in_tready drops.
module midi_chord_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mcg_pkg::TYPE_W-1:0]    cfg_wr_data,   // chord_type
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mcg_pkg::DATA_W-1:0]    in_tdata,      // key, strike, chan, position
  input  logic                          in_tuser,      // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mcg_pkg::DATA_W-1:0]    out_tdata,     // out_key, out_strike, out_chan, out_position
  output logic                          out_tuser,     // is_on
  output logic                          out_tlast      // last
);
  import mcg_pkg::*;

  logic   in_valid_r;
  evt_t   evt_r;
  evt_t   evt_in;
  batch_t batch;
  logic   batch_nonempty;
  logic   can_load;
  logic   fire;
  logic   load;
  key_t    o_key;
  strike_t o_strike;
  chan_t   o_chan;
  pos_t    o_position;

  // Unpack the incoming transaction: key in the lowest bits, then strike,
  // chan and position.
  always_comb begin
    evt_in.opcode   = in_tuser;
    evt_in.key      = in_tdata[KEY_W-1:0];
    evt_in.strike   = in_tdata[KEY_W +: STRIKE_W];
    evt_in.chan     = in_tdata[KEY_W+STRIKE_W +: CHAN_W];
    evt_in.position = in_tdata[KEY_W+STRIKE_W+CHAN_W +: POSITION_BITS];
  end

  // The registered event is processed when it causes no results, or when the
  // sequencer can take its batch in this cycle.
  assign fire      = in_valid_r && (!batch_nonempty || can_load);
  assign load      = fire && batch_nonempty;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) evt_r <= evt_in;
  end

  mcg_note_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .evt            (evt_r),
    .commit         (fire),
    .batch          (batch),
    .batch_nonempty (batch_nonempty)
  );

  mcg_result_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .batch_in     (batch),
    .can_load     (can_load),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_is_on    (out_tuser),
    .out_key      (o_key),
    .out_strike   (o_strike),
    .out_chan     (o_chan),
    .out_position (o_position),
    .out_last     (out_tlast)
  );

  // Pack the result the same way as the input, zero-filled to whole bytes.
  assign out_tdata = {{(DATA_W-KEY_W-STRIKE_W-CHAN_W-POSITION_BITS){1'b0}},
                      o_position, o_chan, o_strike, o_key};

endmodule

// ===== bench/midi_chord_generator_tb.sv =====
// Self-checking testbench of the MIDI chord generator: directed plan, then random phases.
//
// The bench drives note events on the input stream and checks every result
// transaction against its own model of the chord logic. The model keeps the
// held-key map, the sounding flag, the current root and the chord type, and
// for each accepted event it queues the note offs and note ons that the block
// must send.
//
// The run has two parts. A short directed plan comes first. It covers the
// lowest and highest keys, velocity zero on a note on, release of a key that
// is not held, chord notes above 127 being dropped, an undefined chord type
// and a type change while a chord sounds. Rows whose results are obvious
// carry the expected notes typed in; the others go through the model. Then
// eight random phases follow, each with its own chord type, the extremes 0
// and 7 among them. Most random events are well-formed presses and releases
// around a moving key area, so that roots change often and chords are
// released. The rest is noise: velocity-zero note ons, full-range keys and
// releases of keys that were never pressed.
//
// Inputs change on the falling clock edge; outputs are sampled on the rising
// edge, where a transaction counts when tvalid and tready are both high.
// Both sides pause in random bursts, except in the last phase. Once, the
// receiver holds off for a long stretch while the sender keeps offering, so
// the block fills up and drops in_tready.
module midi_chord_generator_tb;
  import mcg_pkg::*;

  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 36;
  localparam int LIMIT_CYCLES = 250000;
  localparam int PLAN_LEN     = 26;
  localparam int SHOW_MAX     = 10;

  // Chord type codes with no interval set of their own; the block plays them
  // as major.
  localparam ctype_t CHORD_UNDEF_LO  = 3'd5;
  localparam ctype_t CHORD_UNDEF_MID = 3'd6;
  localparam ctype_t CHORD_UNDEF_HI  = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [TYPE_W-1:0]  cfg_wr_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [DATA_W-1:0]  in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [DATA_W-1:0]  out_tdata;
  logic               out_tuser;
  logic               out_tlast;

  // One chord note as it leaves the block.
  typedef struct packed {
    logic    on;
    key_t    key;
    strike_t strike;
    chan_t   chan;
    pos_t    pos;
    logic    last;
  } chord_note_t;

  // A step of the directed plan: a register write, an event whose results are
  // typed in below, or an event left to the model.
  typedef enum int {ROW_CFG, ROW_TYPED, ROW_PREDICTED} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        value;
    int        op;
    int        key;
    int        strike;
    int        chan;
    int        pos;
    int        n_res;
    int        n_off;
    int        keys[8];
  } plan_row_t;

  // Typed rows list the note offs first (n_off of them), then the note ons.
  plan_row_t plan [PLAN_LEN] = '{
    // First press after reset: a plain major chord on 60.
    '{ROW_TYPED, 0, OP_NOTE_ON, 60, 100, 0, 16'h0000, 4, 0, '{60, 64, 67, 72, 0, 0, 0, 0}},
    // A higher key does not move the root, so nothing is sent.
    '{ROW_TYPED, 0, OP_NOTE_ON, 62, 1, 3, 16'h0001, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    // A lower key moves the root: old chord off, new chord on.
    '{ROW_TYPED, 0, OP_NOTE_ON, 48, 127, 15, 16'hFFFF, 8, 4,
      '{60, 64, 67, 72, 48, 52, 55, 60}},
    '{ROW_TYPED, 0, OP_NOTE_OFF, 62, 0, 1, 16'h0002, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    // Release of a key that is not held.
    '{ROW_TYPED, 0, OP_NOTE_OFF, 5, 127, 4, 16'h0003, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    // Velocity zero on a note on acts as a release.
    '{ROW_TYPED, 0, OP_NOTE_ON, 60, 0, 6, 16'h0004, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    // Last held key released: the chord goes off.
    '{ROW_TYPED, 0, OP_NOTE_OFF, 48, 0, 9, 16'h1234, 4, 4, '{48, 52, 55, 60, 0, 0, 0, 0}},
    '{ROW_TYPED, 0, OP_NOTE_OFF, 48, 0, 9, 16'h1235, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    // Top key: the three upper chord notes fall off the keyboard.
    '{ROW_TYPED, 0, OP_NOTE_ON, 127, 127, 15, 16'hFFFF, 1, 0, '{127, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_TYPED, 0, OP_NOTE_ON, 0, 64, 0, 16'h0000, 5, 1, '{127, 0, 4, 7, 12, 0, 0, 0}},
    // Releasing the root while another key is held keeps the old root.
    '{ROW_TYPED, 0, OP_NOTE_OFF, 0, 127, 0, 16'h8000, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_TYPED, 0, OP_NOTE_ON, 120, 10, 7, 16'hAAAA, 7, 4,
      '{0, 4, 7, 12, 120, 124, 127, 0}},
    '{ROW_TYPED, 0, OP_NOTE_OFF, 127, 0, 2, 16'h5554, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_TYPED, 0, OP_NOTE_OFF, 120, 0, 2, 16'h5555, 3, 3, '{120, 124, 127, 0, 0, 0, 0, 0}},
    '{ROW_CFG, CHORD_MINOR, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_PREDICTED, 0, OP_NOTE_ON, 64, 90, 5, 16'h0100, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_PREDICTED, 0, OP_NOTE_ON, 57, 90, 5, 16'h0200, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    // Type change while the chord sounds: the offs use the new intervals.
    '{ROW_CFG, CHORD_SEVENTH, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_PREDICTED, 0, OP_NOTE_ON, 40, 77, 11, 16'h0300, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_CFG, CHORD_MAJ_SEVEN, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_PREDICTED, 0, OP_NOTE_OFF, 40, 3, 12, 16'h0400, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_PREDICTED, 0, OP_NOTE_OFF, 64, 0, 13, 16'h0500, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_PREDICTED, 0, OP_NOTE_OFF, 57, 0, 14, 16'h0600, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    // An undefined type plays as major.
    '{ROW_CFG, CHORD_UNDEF_HI, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_PREDICTED, 0, OP_NOTE_ON, 115, 33, 8, 16'h7FFF, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_PREDICTED, 0, OP_NOTE_OFF, 115, 0, 8, 16'h8001, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}}
  };

  ctype_t phase_types [PHASES] = '{CHORD_UNDEF_LO, CHORD_MAJOR, CHORD_UNDEF_MID,
                                   CHORD_MAJ_SEVEN, CHORD_MINOR, CHORD_SUS4,
                                   CHORD_SEVENTH, CHORD_UNDEF_HI};

  // Model state: held keys, sounding flag, root and chord type.
  logic [NOTE_COUNT-1:0] held_keys;
  logic                  sounding;
  key_t                  root_key;
  ctype_t                chord_sel;

  // Notes the block still owes, oldest first, and the notes of one event.
  chord_note_t pending_notes[$];
  chord_note_t chord_batch[$];

  int  mismatches;
  int  events_sent;
  int  notes_seen;
  int  cfg_writes;
  int  typed_rows;
  bit  quiet;
  bit  hold_req;
  bit  holding;

  midi_chord_generator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run must end well inside this bound; a hang in either handshake lands
  // here.
  initial begin
    #(4 * LIMIT_CYCLES);
    $display("timeout: %0d notes still expected", pending_notes.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Interval i of the chord selected by t.
  function automatic int chord_step(input ctype_t t, input int i);
    int steps[4];
    case (t)
      CHORD_MINOR:     steps = '{0, 3, 7, 12};
      CHORD_SEVENTH:   steps = '{0, 4, 7, 10};
      CHORD_MAJ_SEVEN: steps = '{0, 4, 7, 11};
      CHORD_SUS4:      steps = '{0, 5, 7, 12};
      default:         steps = '{0, 4, 7, 12};
    endcase
    return steps[i];
  endfunction

  function automatic key_t lowest_key();
    key_t k;
    k = '0;
    for (int i = NOTE_COUNT - 1; i >= 0; i--) begin
      if (held_keys[i]) k = key_t'(i);
    end
    return k;
  endfunction

  // Appends the chord on root to chord_batch, dropping notes above the top key.
  function automatic void add_chord(input key_t root, input logic on, input evt_t e);
    int          n;
    chord_note_t r;
    for (int i = 0; i < CHORD_NOTES; i++) begin
      n = int'(root) + chord_step(chord_sel, i);
      if (n < NOTE_COUNT) begin
        r.on     = on;
        r.key    = key_t'(n);
        r.strike = on ? e.strike : '0;
        r.chan   = e.chan;
        r.pos    = e.position;
        r.last   = 1'b0;
        chord_batch.push_back(r);
      end
    end
  endfunction

  // Advances the model by one accepted event. With queue_notes set, the notes
  // it causes join the list of expected results.
  task automatic predict_chord(input evt_t e, input bit queue_notes);
    key_t        low;
    chord_note_t r;
    chord_batch.delete();
    if (e.opcode == OP_NOTE_ON && e.strike != '0) begin
      held_keys[e.key] = 1'b1;
      low = lowest_key();
      if (low != root_key || !sounding) begin
        if (sounding) add_chord(root_key, 1'b0, e);
        add_chord(low, 1'b1, e);
        root_key = low;
        sounding = 1'b1;
      end
    end else begin
      held_keys[e.key] = 1'b0;
      if (held_keys == '0 && sounding) begin
        add_chord(root_key, 1'b0, e);
        sounding = 1'b0;
      end
    end
    if (chord_batch.size() > 0) begin
      r = chord_batch.pop_back();
      r.last = 1'b1;
      chord_batch.push_back(r);
    end
    if (queue_notes) begin
      foreach (chord_batch[i]) pending_notes.push_back(chord_batch[i]);
    end
  endtask

  // Offers one event and returns once the block has taken it. A random pause
  // may come first, except in the quiet phase and while the receiver holds
  // off, since the sender must keep pushing then.
  task automatic offer_event(input evt_t e);
    if (!quiet && !holding && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= e.opcode;
    in_tdata  <= DATA_W'({e.position, e.chan, e.strike, e.key});
    do @(posedge clk); while (!in_tready);
    events_sent++;
  endtask

  task automatic play(input evt_t e);
    offer_event(e);
    predict_chord(e, 1'b1);
  endtask

  // Stops the sender and waits until the block has sent everything it owes,
  // plus a drain margin for an event that causes no result.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_chord_type(input ctype_t v);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    chord_sel = v;
    cfg_writes++;
  endtask

  // A key chosen at random among the held ones, or -1 when none is held.
  function automatic int pick_held();
    int count;
    int idx;
    count = $countones(held_keys);
    if (count == 0) return -1;
    idx = $urandom_range(0, count - 1);
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (held_keys[i]) begin
        if (idx == 0) return i;
        idx--;
      end
    end
    return -1;
  endfunction

  // Receiver: random stalls, one long hold-off on request,
  // and always ready in the quiet phase.
  initial begin
    out_tready = 1'b0;
    holding    = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_tready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
        holding = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker: each transaction on the output side is compared field by
  // field with the oldest expected note.
  always @(posedge clk) begin
    chord_note_t got;
    chord_note_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.on     = out_tuser;
      got.key    = out_tdata[KEY_W-1:0];
      got.strike = out_tdata[KEY_W +: STRIKE_W];
      got.chan   = out_tdata[KEY_W+STRIKE_W +: CHAN_W];
      got.pos    = out_tdata[KEY_W+STRIKE_W+CHAN_W +: POSITION_BITS];
      got.last   = out_tlast;
      notes_seen++;
      if (pending_notes.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected result: on %0d key %0d strike %0d chan %0d pos %h last %0d",
                   got.on, got.key, got.strike, got.chan, got.pos, got.last);
      end else begin
        want = pending_notes.pop_front();
        if (got.on !== want.on || got.key !== want.key || got.strike !== want.strike ||
            got.chan !== want.chan || got.pos !== want.pos || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= SHOW_MAX) begin
            $display("mismatch at note %0d:", notes_seen);
            $display("  expected on %0d key %0d strike %0d chan %0d pos %h last %0d",
                     want.on, want.key, want.strike, want.chan, want.pos, want.last);
            $display("  actual   on %0d key %0d strike %0d chan %0d pos %h last %0d",
                     got.on, got.key, got.strike, got.chan, got.pos, got.last);
          end
        end
      end
    end
  end

  initial begin
    evt_t        e;
    chord_note_t r;
    int          base;
    int          n;
    int          pick;
    int          sel;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    held_keys   = '0;
    sounding    = 1'b0;
    root_key    = '0;
    chord_sel   = CHORD_MAJOR;
    mismatches  = 0;
    events_sent = 0;
    notes_seen  = 0;
    cfg_writes  = 0;
    typed_rows  = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed plan. Typed rows still run the model, so its state follows
    // the block, but their expected notes come from the row itself.
    foreach (plan[p]) begin
      if (plan[p].kind == ROW_CFG) begin
        write_chord_type(ctype_t'(plan[p].value));
      end else begin
        e.opcode   = plan[p].op[0];
        e.key      = key_t'(plan[p].key);
        e.strike   = strike_t'(plan[p].strike);
        e.chan     = chan_t'(plan[p].chan);
        e.position = pos_t'(plan[p].pos);
        offer_event(e);
        if (plan[p].kind == ROW_TYPED) begin
          predict_chord(e, 1'b0);
          typed_rows++;
          for (int i = 0; i < plan[p].n_res; i++) begin
            r.on     = (i >= plan[p].n_off);
            r.key    = key_t'(plan[p].keys[i]);
            r.strike = r.on ? e.strike : '0;
            r.chan   = e.chan;
            r.pos    = e.position;
            r.last   = (i == plan[p].n_res - 1);
            pending_notes.push_back(r);
          end
        end else begin
          predict_chord(e, 1'b1);
        end
      end
    end

    // Random phases, one chord type each. The long receiver hold-off falls in
    // the second phase; the last phase runs without pauses on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_chord_type(phase_types[ph]);
      if (ph == 1) hold_req = 1'b1;
      if (ph == PHASES - 1) quiet = 1'b1;
      base = $urandom_range(0, 120);
      n = 0;
      while (n < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        e.chan     = chan_t'($urandom_range(0, 15));
        e.position = pos_t'($urandom);
        if (sel < 5) begin
          // Release everything that is held, one key at a time.
          pick = pick_held();
          while (pick >= 0) begin
            e.opcode = OP_NOTE_OFF;
            e.key    = key_t'(pick);
            e.strike = strike_t'($urandom_range(0, 127));
            play(e);
            n++;
            pick = pick_held();
          end
        end else if (sel < 50) begin
          // Press a key in the current area.
          e.opcode = OP_NOTE_ON;
          e.key    = key_t'((base + $urandom_range(0, 12) > 127) ? 127
                                                              : base + $urandom_range(0, 12));
          e.strike = strike_t'($urandom_range(1, 127));
          play(e);
          n++;
        end else if (sel < 85) begin
          // Release a held key, either way a release can be written.
          pick = pick_held();
          if (pick < 0) pick = $urandom_range(0, 127);
          if (sel < 78) begin
            e.opcode = OP_NOTE_OFF;
            e.strike = strike_t'($urandom_range(0, 127));
          end else begin
            e.opcode = OP_NOTE_ON;
            e.strike = '0;
          end
          e.key = key_t'(pick);
          play(e);
          n++;
        end else if (sel < 93) begin
          // Press anywhere on the keyboard, the edges included.
          e.opcode = OP_NOTE_ON;
          case ($urandom_range(0, 3))
            0:       e.key = '0;
            1:       e.key = key_t'(NOTE_COUNT - 1);
            default: e.key = key_t'($urandom_range(0, 127));
          endcase
          e.strike = strike_t'($urandom_range(1, 127));
          play(e);
          n++;
        end else begin
          // Release of an arbitrary key, mostly one that is not held.
          e.opcode = OP_NOTE_OFF;
          e.key    = key_t'($urandom_range(0, 127));
          e.strike = strike_t'($urandom_range(0, 127));
          play(e);
          n++;
        end
        // Let the key area wander so the root keeps moving.
        if ($urandom_range(0, 9) == 0) base = $urandom_range(0, 120);
      end
    end

    wait_idle();

    $display("sent %0d note events (%0d with hand-written results), checked %0d chord notes",
             events_sent, typed_rows, notes_seen);
    $display("chord type written %0d times, codes 0 to 7, one long receiver stall",
             cfg_writes);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
